// ----- src/brve_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary RPC value encoder package
// Shared payload types, operation codes and type-byte constants.
// ----------------------------------------------------------------------------
`default_nettype none

package brve_pkg;

	// Operation codes.
	localparam logic [3:0] OP_HDR    = 4'd0;
	localparam logic [3:0] OP_CALL   = 4'd1;
	localparam logic [3:0] OP_RESP   = 4'd2;
	localparam logic [3:0] OP_FAULT  = 4'd3;
	localparam logic [3:0] OP_MEMBER = 4'd4;
	localparam logic [3:0] OP_INT32  = 4'd5;
	localparam logic [3:0] OP_INT64  = 4'd6;
	localparam logic [3:0] OP_BOOL   = 4'd7;
	localparam logic [3:0] OP_DOUBLE = 4'd8;
	localparam logic [3:0] OP_STR    = 4'd9;
	localparam logic [3:0] OP_BIN    = 4'd10;
	localparam logic [3:0] OP_ARRAY  = 4'd11;
	localparam logic [3:0] OP_STRUCT = 4'd12;

	// Type bytes.
	localparam logic [7:0] HDR_B0     = 8'hCA;
	localparam logic [7:0] HDR_B1     = 8'h11;
	localparam logic [7:0] HDR_V2     = 8'h02;
	localparam logic [7:0] HDR_V1     = 8'h01;
	localparam logic [7:0] HDR_B3     = 8'h00;
	localparam logic [7:0] T_CALL     = 8'h68;
	localparam logic [7:0] T_RESP     = 8'h70;
	localparam logic [7:0] T_FAULT    = 8'h78;
	localparam logic [7:0] T_INT_NEG  = 8'h40;
	localparam logic [7:0] T_INT_POS  = 8'h38;
	localparam logic [7:0] T_INT_V1   = 8'h08;
	localparam logic [7:0] T_BOOL     = 8'h10;
	localparam logic [7:0] T_DOUBLE   = 8'h18;
	localparam logic [7:0] T_STR      = 8'h20;
	localparam logic [7:0] T_BIN      = 8'h30;
	localparam logic [7:0] T_ARRAY    = 8'h58;
	localparam logic [7:0] T_STRUCT   = 8'h50;

	// Width codes: number of data bytes minus one.
	localparam logic [2:0] WC_1 = 3'd0;
	localparam logic [2:0] WC_2 = 3'd1;
	localparam logic [2:0] WC_4 = 3'd3;
	localparam logic [2:0] WC_7 = 3'd6;
	localparam logic [2:0] WC_8 = 3'd7;

	// Most bytes one item can produce.
	localparam int unsigned MAX_BYTES = 9;
	localparam int unsigned CNT_W     = 4;

	// Configuration register word index.
	localparam logic REG_VERSION = 1'b0;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [63:0] value;
		logic [63:0]        length;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       error;
	} result_t;

	// Fewest of 1, 2, 4 or 8 bytes that hold an unsigned count.
	function automatic logic [2:0] width_code(input logic [63:0] m);
		logic [2:0] c;
		if (m[63:8] == 56'd0) begin
			c = WC_1;
		end else if (m[63:16] == 48'd0) begin
			c = WC_2;
		end else if (m[63:32] == 32'd0) begin
			c = WC_4;
		end else begin
			c = WC_8;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- src/binary_rpc_value_encoder.sv -----
// ----------------------------------------------------------------------------
// Binary RPC value encoder
// Turns one command into the type byte and little-endian value bytes of a
// binary RPC encoding, one byte per cycle on a strobed result port.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. It is registered,
// encoded combinationally and loaded into a byte buffer, and its bytes then
// leave one per cycle on result with strobe high; the receiver cannot stall
// them. The byte buffer refills in the cycle its final byte leaves, and the
// input register can take the next command while the buffer still sends;
// intake stalls only while that register is full and the buffer is not on
// its last byte. Operations 13 to 15 produce no byte.
`default_nettype none

module binary_rpc_value_encoder (
	input  wire                  clk,
	input  wire                  arst_n,
	// Command channel
	input  wire                  start,
	output logic                 busy,
	input  wire brve_pkg::cmd_t  cmd,
	// Result channel
	output logic                 strobe,
	output brve_pkg::result_t    result,
	// Configuration port
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire  [2:0]           paddr,
	input  wire  [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// ---------------------------------------------------------------- config
	logic v2_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == brve_pkg::REG_VERSION) ? {31'd0, v2_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b1;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == brve_pkg::REG_VERSION) begin
			v2_q <= pwdata[0];
		end
	end

	// ----------------------------------------------------------- input stage
	logic                     valid_s1;
	brve_pkg::cmd_t           cmd_s1;
	logic [brve_pkg::CNT_W-1:0] cnt_s2;
	logic                     load;
	logic                     take;

	// The buffer can take a new item when it is empty or sending its last byte.
	assign load = valid_s1 && (cnt_s2 <= brve_pkg::CNT_W'(1));
	assign busy = valid_s1 && !load;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
	end

	// -------------------------------------------------------------- encoding
	logic [7:0]                 enc_byte [brve_pkg::MAX_BYTES];
	logic [brve_pkg::CNT_W-1:0] enc_cnt;
	logic                       enc_err;

	logic [31:0] u32;
	logic        neg32;
	logic [31:0] mag32;
	logic        neg64;
	logic [63:0] mag64;
	logic [2:0]  code_raw;
	logic [2:0]  code_adj;
	logic [7:0]  base;
	logic [7:0]  tbyte;
	logic [63:0] data;
	logic        typed;

	always_comb begin
		u32   = cmd_s1.value[31:0];
		neg32 = u32[31];
		mag32 = neg32 ? (32'd0 - u32) : u32;
		neg64 = cmd_s1.value[63];
		mag64 = neg64 ? (64'd0 - cmd_s1.value) : cmd_s1.value;

		typed    = 1'b0;
		base     = brve_pkg::T_STR;
		code_raw = brve_pkg::WC_1;
		data     = cmd_s1.length;
		enc_cnt  = '0;
		enc_err  = 1'b0;
		for (int i = 0; i < brve_pkg::MAX_BYTES; i++) begin
			enc_byte[i] = 8'd0;
		end

		case (cmd_s1.op)
			brve_pkg::OP_HDR: begin
				enc_byte[0] = brve_pkg::HDR_B0;
				enc_byte[1] = brve_pkg::HDR_B1;
				enc_byte[2] = v2_q ? brve_pkg::HDR_V2 : brve_pkg::HDR_V1;
				enc_byte[3] = brve_pkg::HDR_B3;
				enc_cnt     = brve_pkg::CNT_W'(4);
			end
			brve_pkg::OP_CALL: begin
				enc_byte[0] = brve_pkg::T_CALL;
				enc_byte[1] = cmd_s1.length[7:0];
				enc_cnt     = brve_pkg::CNT_W'(2);
			end
			brve_pkg::OP_RESP: begin
				enc_byte[0] = brve_pkg::T_RESP;
				enc_cnt     = brve_pkg::CNT_W'(1);
			end
			brve_pkg::OP_FAULT: begin
				enc_byte[0] = brve_pkg::T_FAULT;
				enc_cnt     = brve_pkg::CNT_W'(1);
			end
			brve_pkg::OP_MEMBER: begin
				enc_cnt = brve_pkg::CNT_W'(1);
				if (cmd_s1.length[63:8] != 56'd0) begin
					enc_err = 1'b1;
				end else begin
					enc_byte[0] = cmd_s1.length[7:0];
				end
			end
			brve_pkg::OP_INT32: begin
				typed = 1'b1;
				if (v2_q) begin
					base     = neg32 ? brve_pkg::T_INT_NEG : brve_pkg::T_INT_POS;
					code_raw = brve_pkg::width_code({32'd0, mag32});
					data     = {32'd0, mag32};
				end else begin
					base = brve_pkg::T_INT_V1;
					data = {32'd0, u32};
					if (u32[31:15] != 17'd0) begin
						code_raw = brve_pkg::WC_4;
					end else if (u32[14:7] != 8'd0) begin
						code_raw = brve_pkg::WC_2;
					end else begin
						code_raw = brve_pkg::WC_1;
					end
				end
			end
			brve_pkg::OP_INT64: begin
				typed = 1'b1;
				if (v2_q) begin
					base     = neg64 ? brve_pkg::T_INT_NEG : brve_pkg::T_INT_POS;
					code_raw = brve_pkg::width_code(mag64);
					data     = mag64;
				end else begin
					base = brve_pkg::T_INT_V1;
					data = cmd_s1.value;
					if (cmd_s1.value[63:31] != 33'd0) begin
						code_raw = brve_pkg::WC_8;
					end else if (cmd_s1.value[30:15] != 16'd0) begin
						code_raw = brve_pkg::WC_4;
					end else if (cmd_s1.value[14:7] != 8'd0) begin
						code_raw = brve_pkg::WC_2;
					end else begin
						code_raw = brve_pkg::WC_1;
					end
				end
			end
			brve_pkg::OP_BOOL: begin
				enc_byte[0] = brve_pkg::T_BOOL | {7'd0, cmd_s1.value[0]};
				enc_cnt     = brve_pkg::CNT_W'(1);
			end
			brve_pkg::OP_DOUBLE: begin
				enc_byte[0] = brve_pkg::T_DOUBLE;
				for (int i = 0; i < 8; i++) begin
					enc_byte[i+1] = cmd_s1.value[8*i +: 8];
				end
				enc_cnt = brve_pkg::CNT_W'(9);
			end
			brve_pkg::OP_STR: begin
				typed    = 1'b1;
				base     = brve_pkg::T_STR;
				code_raw = brve_pkg::width_code(cmd_s1.length);
			end
			brve_pkg::OP_BIN: begin
				typed    = 1'b1;
				base     = brve_pkg::T_BIN;
				code_raw = brve_pkg::width_code(cmd_s1.length);
			end
			brve_pkg::OP_ARRAY: begin
				typed    = 1'b1;
				base     = brve_pkg::T_ARRAY;
				code_raw = brve_pkg::width_code(cmd_s1.length);
			end
			brve_pkg::OP_STRUCT: begin
				typed    = 1'b1;
				base     = brve_pkg::T_STRUCT;
				code_raw = brve_pkg::width_code(cmd_s1.length);
			end
			default: begin
				enc_cnt = '0;
			end
		endcase

		// Version 1 has no 8-byte form: wide values go out as their low 7 bytes,
		// and each type byte built here is one above its base ORed with the width code.
		code_adj = (!v2_q && code_raw == brve_pkg::WC_8) ? brve_pkg::WC_7 : code_raw;
		tbyte    = base | {5'd0, code_adj};
		if (!v2_q) begin
			tbyte = tbyte + 8'd1;
		end

		if (typed) begin
			enc_byte[0] = tbyte;
			for (int i = 0; i < 8; i++) begin
				enc_byte[i+1] = data[8*i +: 8];
			end
			enc_cnt = brve_pkg::CNT_W'(code_adj) + brve_pkg::CNT_W'(2);
		end
	end

	// ------------------------------------------------------------ byte buffer
	logic [7:0] shr_s2 [brve_pkg::MAX_BYTES];
	logic       err_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (load) begin
			cnt_s2 <= enc_cnt;
		end else if (cnt_s2 != '0) begin
			cnt_s2 <= cnt_s2 - brve_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shr_s2 <= enc_byte;
			err_s2 <= enc_err;
		end else begin
			for (int i = 0; i < brve_pkg::MAX_BYTES - 1; i++) begin
				shr_s2[i] <= shr_s2[i+1];
			end
			shr_s2[brve_pkg::MAX_BYTES-1] <= 8'd0;
		end
	end

	assign strobe          = (cnt_s2 != '0);
	assign result.out_byte = shr_s2[0];
	assign result.last     = (cnt_s2 == brve_pkg::CNT_W'(1));
	assign result.error    = err_s2 && (cnt_s2 == brve_pkg::CNT_W'(1));

endmodule

`default_nettype wire

// ----- tb/binary_rpc_value_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary RPC value encoder testbench
// Sends directed and random commands under both protocol versions through a
// queued driver, predicts the encoded byte stream and checks every strobed
// byte against it. The version register is rewritten and read back between
// phases while the encoder is idle.
// ----------------------------------------------------------------------------

module binary_rpc_value_encoder_tb;

	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         DRAIN_CYCLES = 16;
	localparam logic [2:0] ADDR_VERSION = {brve_pkg::REG_VERSION, 2'b00};
	localparam logic [2:0] ADDR_UNUSED  = 3'd4;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	brve_pkg::cmd_t    cmd;
	logic              strobe;
	brve_pkg::result_t result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	brve_pkg::cmd_t    pending_cmds[$];
	brve_pkg::result_t expected_bytes[$];
	brve_pkg::result_t want_byte;
	logic              cfg_version2;
	logic              gaps_on;
	int                idle_left;
	int                mismatches;
	int                cmds_sent;
	int                bytes_checked;
	int                cfg_writes;
	int                cycles;

	binary_rpc_value_encoder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.strobe  (strobe),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Fewest of 1, 2, 4 or 8 bytes, as a width code.
	function automatic logic [2:0] count_width(input logic [63:0] m);
		if (m[63:8] == '0) return brve_pkg::WC_1;
		if (m[63:16] == '0) return brve_pkg::WC_2;
		if (m[63:32] == '0) return brve_pkg::WC_4;
		return brve_pkg::WC_8;
	endfunction

	// Appends the bytes that one command must produce to expected_bytes.
	task automatic encode_expected(input brve_pkg::cmd_t c);
		logic [7:0]  seq [0:8];
		logic [7:0]  tbyte;
		logic [7:0]  base;
		logic [2:0]  code;
		logic [63:0] data;
		logic [63:0] mag;
		logic [31:0] u32;
		logic        neg;
		logic        typed;
		logic        err;
		int          n;
		int          i;
		n = 0;
		err = 1'b0;
		typed = 1'b0;
		base = '0;
		code = brve_pkg::WC_1;
		data = '0;
		case (c.op)
			brve_pkg::OP_HDR: begin
				seq[0] = brve_pkg::HDR_B0;
				seq[1] = brve_pkg::HDR_B1;
				seq[2] = cfg_version2 ? brve_pkg::HDR_V2 : brve_pkg::HDR_V1;
				seq[3] = brve_pkg::HDR_B3;
				n = 4;
			end
			brve_pkg::OP_CALL: begin
				seq[0] = brve_pkg::T_CALL;
				seq[1] = c.length[7:0];
				n = 2;
			end
			brve_pkg::OP_RESP: begin
				seq[0] = brve_pkg::T_RESP;
				n = 1;
			end
			brve_pkg::OP_FAULT: begin
				seq[0] = brve_pkg::T_FAULT;
				n = 1;
			end
			brve_pkg::OP_MEMBER: begin
				if (c.length > 64'd255) begin
					seq[0] = 8'h00;
					err = 1'b1;
				end else begin
					seq[0] = c.length[7:0];
				end
				n = 1;
			end
			brve_pkg::OP_INT32: begin
				u32 = c.value[31:0];
				neg = u32[31];
				typed = 1'b1;
				if (cfg_version2) begin
					// The most negative value negates to itself, read as 2^31.
					mag = {32'd0, neg ? (~u32 + 32'd1) : u32};
					base = neg ? brve_pkg::T_INT_NEG : brve_pkg::T_INT_POS;
					code = count_width(mag);
					data = mag;
				end else begin
					base = brve_pkg::T_INT_V1;
					data = {32'd0, u32};
					if (neg || u32[30:15] != '0) begin
						code = brve_pkg::WC_4;
					end else if (u32[14:7] != '0) begin
						code = brve_pkg::WC_2;
					end else begin
						code = brve_pkg::WC_1;
					end
				end
			end
			brve_pkg::OP_INT64: begin
				neg = c.value[63];
				typed = 1'b1;
				if (cfg_version2) begin
					mag = neg ? (~c.value + 64'd1) : c.value;
					base = neg ? brve_pkg::T_INT_NEG : brve_pkg::T_INT_POS;
					code = count_width(mag);
					data = mag;
				end else begin
					base = brve_pkg::T_INT_V1;
					data = c.value;
					if (neg || c.value[62:31] != '0) begin
						code = brve_pkg::WC_8;
					end else if (c.value[30:15] != '0) begin
						code = brve_pkg::WC_4;
					end else if (c.value[14:7] != '0) begin
						code = brve_pkg::WC_2;
					end else begin
						code = brve_pkg::WC_1;
					end
				end
			end
			brve_pkg::OP_BOOL: begin
				seq[0] = brve_pkg::T_BOOL | {7'd0, c.value[0]};
				n = 1;
			end
			brve_pkg::OP_DOUBLE: begin
				seq[0] = brve_pkg::T_DOUBLE;
				for (i = 0; i < 8; i++) seq[i + 1] = c.value[8 * i +: 8];
				n = 9;
			end
			brve_pkg::OP_STR, brve_pkg::OP_BIN,
			brve_pkg::OP_ARRAY, brve_pkg::OP_STRUCT: begin
				typed = 1'b1;
				case (c.op)
					brve_pkg::OP_STR:   base = brve_pkg::T_STR;
					brve_pkg::OP_BIN:   base = brve_pkg::T_BIN;
					brve_pkg::OP_ARRAY: base = brve_pkg::T_ARRAY;
					default:            base = brve_pkg::T_STRUCT;
				endcase
				code = count_width(c.length);
				data = c.length;
			end
			default: n = 0;
		endcase
		if (typed) begin
			// Version 1 has no 8-byte form and shifts every width code up by one.
			if (!cfg_version2 && code == brve_pkg::WC_8) code = brve_pkg::WC_7;
			tbyte = base | {5'd0, code};
			if (!cfg_version2) tbyte = tbyte + 8'd1;
			seq[0] = tbyte;
			for (i = 0; i <= int'(code); i++) seq[i + 1] = data[8 * i +: 8];
			n = int'(code) + 2;
		end
		for (i = 0; i < n; i++) expected_bytes.push_back('{seq[i], i == n - 1, err});
	endtask

	// Command driver: holds start until the command is taken, then may idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			idle_left = 0;
		end else begin
			if (start && !busy) begin
				encode_expected(cmd);
				void'(pending_cmds.pop_front());
				cmds_sent++;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				if (gaps_on && $urandom_range(0, 3) == 0) begin
					idle_left = $urandom_range(0, 2);
					start <= 1'b0;
				end else begin
					start <= 1'b1;
					cmd <= pending_cmds[0];
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %b error %b",
					result.out_byte, result.last, result.error));
			end else begin
				want_byte = expected_bytes.pop_front();
				if (result.out_byte !== want_byte.out_byte)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						result.out_byte, want_byte.out_byte));
				if (result.last !== want_byte.last)
					report_mismatch($sformatf("last %b, expected %b on byte %02h",
						result.last, want_byte.last, want_byte.out_byte));
				if (result.error !== want_byte.error)
					report_mismatch($sformatf("error %b, expected %b on byte %02h",
						result.error, want_byte.error, want_byte.out_byte));
				bytes_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes outstanding", cycles,
				expected_bytes.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_VERSION) cfg_version2 = data[0];
		cfg_writes++;
	endtask

	task automatic check_version_reg();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_VERSION;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'd0, cfg_version2})
			report_mismatch($sformatf("version register reads %h, expected %0d",
				prdata, cfg_version2));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_cmd(input logic [3:0] op, input logic [63:0] value,
			input logic [63:0] length);
		brve_pkg::cmd_t c;
		c.op = op;
		c.value = value;
		c.length = length;
		pending_cmds.push_back(c);
	endtask

	// Extremes of every operation, size boundaries and the odd cases.
	task automatic queue_directed();
		add_cmd(brve_pkg::OP_HDR, '1, '1);
		add_cmd(brve_pkg::OP_CALL, '0, 64'h1234_5678_9ABC_DEFF);
		add_cmd(brve_pkg::OP_CALL, '0, '0);
		add_cmd(brve_pkg::OP_RESP, '0, '0);
		add_cmd(brve_pkg::OP_FAULT, '1, '1);
		add_cmd(brve_pkg::OP_MEMBER, '0, 64'd255);
		add_cmd(brve_pkg::OP_MEMBER, '0, 64'd256);
		add_cmd(brve_pkg::OP_MEMBER, '0, '1);
		add_cmd(brve_pkg::OP_INT32, '0, '0);
		add_cmd(brve_pkg::OP_INT32, 64'hDEAD_BEEF_7FFF_FFFF, '0);
		add_cmd(brve_pkg::OP_INT32, 64'h0000_0000_8000_0000, '0);
		add_cmd(brve_pkg::OP_INT32, '1, '0);
		add_cmd(brve_pkg::OP_INT32, 64'd128, '0);
		add_cmd(brve_pkg::OP_INT64, 64'h8000_0000_0000_0000, '0);
		add_cmd(brve_pkg::OP_INT64, 64'h7FFF_FFFF_FFFF_FFFF, '0);
		add_cmd(brve_pkg::OP_INT64, 64'h0000_0000_8000_0000, '0);
		add_cmd(brve_pkg::OP_INT64, -64'sd129, '0);
		add_cmd(brve_pkg::OP_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, '0);
		add_cmd(brve_pkg::OP_BOOL, 64'd1, '0);
		add_cmd(brve_pkg::OP_DOUBLE, 64'h8000_0000_0000_0001, '0);
		add_cmd(brve_pkg::OP_STR, '0, '0);
		add_cmd(brve_pkg::OP_BIN, '0, 64'd65536);
		add_cmd(brve_pkg::OP_ARRAY, '0, 64'hFFFF_FFFF);
		add_cmd(brve_pkg::OP_STRUCT, '0, '1);
		add_cmd(4'd13, '1, '1);
		add_cmd(4'd15, '0, '0);
	endtask

	// Values spread over the size boundaries, with random sign.
	function automatic logic [63:0] rand_sized();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: raw = raw & 64'hFF;
			1: raw = raw & 64'hFFFF;
			2: raw = raw & 64'hFFFF_FFFF;
			3: raw = raw & 64'h00FF_FFFF_FFFF_FFFF;
			4: raw = 64'd1 << ($urandom_range(0, 63));
			default: raw = raw;
		endcase
		if ($urandom_range(0, 7) == 0) raw = raw - 64'd1;
		if ($urandom_range(0, 2) == 0) raw = ~raw + 64'd1;
		return raw;
	endfunction

	task automatic queue_random(input int count);
		int             sent;
		brve_pkg::cmd_t c;
		sent = 0;
		while (sent < count) begin
			c.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
				: 4'($urandom_range(0, 12));
			c.value = rand_sized();
			c.length = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 300))
				: rand_sized();
			pending_cmds.push_back(c);
			if (c.op <= brve_pkg::OP_STRUCT) sent++;
		end
	endtask

	// Lets the encoder go idle: all commands taken and all bytes seen.
	task automatic wait_idle();
		while (pending_cmds.size() != 0 || start || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_version2 = 1'b1;
		gaps_on = 1'b1;
		mismatches = 0;
		cmds_sent = 0;
		bytes_checked = 0;
		cfg_writes = 0;
		cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		check_version_reg();

		queue_directed();
		wait_idle();
		// A write beyond the register list must leave the version alone.
		apb_write(ADDR_UNUSED, 32'h0);
		check_version_reg();
		apb_write(ADDR_VERSION, 32'hFFFF_FFFE);
		check_version_reg();
		queue_directed();
		wait_idle();

		queue_random(170);
		wait_idle();
		apb_write(ADDR_VERSION, 32'h1);
		check_version_reg();
		queue_random(170);
		wait_idle();
		apb_write(ADDR_VERSION, 32'h0);
		check_version_reg();
		queue_random(80);
		wait_idle();
		gaps_on = 1'b0;
		apb_write(ADDR_VERSION, 32'h1);
		check_version_reg();
		queue_random(80);
		wait_idle();

		if (expected_bytes.size() != 0)
			report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
		$display("Covered %0d commands and %0d encoded bytes under both versions,",
			cmds_sent, bytes_checked);
		$display("with %0d register writes and %0d mismatches.", cfg_writes, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/brve_pkg.sv
src/binary_rpc_value_encoder.sv
tb/binary_rpc_value_encoder_tb.sv
